@@ sv/bhc_pkg.sv @@
// Shared types and constants for the binned histogram counter.
// No dependencies.
`default_nettype none
package bhc_pkg;
    localparam logic [1:0] ACT_ADD_VALUE = 2'd0;
    localparam logic [1:0] ACT_ADD_BIN   = 2'd1;
    localparam logic [1:0] ACT_READ_BIN  = 2'd2;

    localparam logic [1:0] PLACE_INSIDE = 2'd0;
    localparam logic [1:0] PLACE_BELOW  = 2'd1;
    localparam logic [1:0] PLACE_ABOVE  = 2'd2;

    localparam logic [1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
    localparam logic [1:0] REG_BINS_USED = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] sample_value;
        logic signed [31:0] bin_select;
    } t_in_item;

    typedef struct packed {
        logic signed [32:0] computed_bin;
        logic [1:0]         placement;
        logic [31:0]        bin_count;
        logic [31:0]        total_entries;
        logic [31:0]        underflow_total;
        logic [31:0]        overflow_total;
    } t_out_item;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture input item, start division
        logic div_step;  // one restoring division step
        logic resolve;   // form bin index and placement, issue RAM read
        logic update;    // write back counters, build result
        logic clr_step;  // clearing pass: zero one RAM entry
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic is_divide;
        logic div_last;
        logic clr_last;
    } t_sts;
endpackage
`default_nettype wire

@@ sv/binned_histogram_counter.sv @@
// Top level of the binned histogram counter: APB register file, controller
// and datapath. Depends on bhc_pkg, bhc_ctrl, bhc_dp (and bhc_ram below it).
`default_nettype none
// Equal-width histogram with underflow and overflow counters. Each item is
// one action: add value (bin = floor((sample - range_minimum) / bin width)),
// add to a given bin, or read a given bin; every add also bumps the entry
// total, and all counts saturate at all-ones. Items are handled one at a
// time. Add value runs a 33-step restoring divider that yields one quotient
// bit per cycle, then resolve, RAM read and update; the other actions pass
// through the divide state once, then resolve, RAM read and update. The
// result is held in an output register until taken, and the next item is
// accepted the cycle after that. After reset the bin store is swept to zero
// one entry a cycle, over all NUM_BINS entries, with input ready low;
// register writes are taken throughout. A bin width of zero acts as one,
// and bins_in_use above NUM_BINS acts as NUM_BINS.
module binned_histogram_counter #(
    parameter int NUM_BINS = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  bhc_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output bhc_pkg::t_out_item   o_out_item,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [3:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic signed [31:0] r_range_minimum;
    logic [30:0]        r_bin_span;
    logic [8:0]         r_bins_in_use;
    logic [1:0]         w_reg;
    bhc_pkg::t_cmd      w_cmd;
    bhc_pkg::t_sts      w_sts;

    assign pready = 1'b1;
    assign w_reg  = paddr[3:2];

    // register writes land on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_minimum <= '0;
            r_bin_span      <= 31'd1;
            r_bins_in_use   <= 9'd256;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                bhc_pkg::REG_RANGE_MIN: r_range_minimum <= pwdata;
                bhc_pkg::REG_BIN_WIDTH: r_bin_span      <= pwdata[30:0];
                bhc_pkg::REG_BINS_USED: r_bins_in_use   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            bhc_pkg::REG_RANGE_MIN: prdata = r_range_minimum;
            bhc_pkg::REG_BIN_WIDTH: prdata = {1'b0, r_bin_span};
            bhc_pkg::REG_BINS_USED: prdata = {23'd0, r_bins_in_use};
            default:                prdata = '0;
        endcase
    end

    bhc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    bhc_dp #(.NUM_BINS(NUM_BINS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_item          (i_in_item),
        .i_range_minimum (r_range_minimum),
        .i_bin_span      (r_bin_span),
        .i_bins_in_use   (r_bins_in_use),
        .o_item          (o_out_item)
    );
endmodule
`default_nettype wire

@@ sv/bhc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module bhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/bhc_ctrl.sv @@
// Controller for the binned histogram counter.
// Depends on bhc_pkg.
`default_nettype none
module bhc_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output bhc_pkg::t_cmd  o_cmd,
    input  bhc_pkg::t_sts  i_sts
);
    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_DIVIDE  = 3'd2;
    localparam logic [2:0] ST_RESOLVE = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;
    localparam logic [2:0] ST_UPDATE  = 3'd5;
    localparam logic [2:0] ST_OUT     = 3'd6;

    logic [2:0] r_state, n_state;
    logic       w_accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (!i_sts.is_divide) begin
                    n_state = ST_RESOLVE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_sts.div_last) n_state = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = ST_READ;
            end
            ST_READ: n_state = ST_UPDATE;
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

@@ sv/bhc_dp.sv @@
// Datapath for the binned histogram counter: divider, range check,
// bin store and saturating counters. Depends on bhc_pkg and bhc_ram.
`default_nettype none
module bhc_dp #(
    parameter int NUM_BINS = 256
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  bhc_pkg::t_cmd          i_cmd,
    output bhc_pkg::t_sts          o_sts,
    input  bhc_pkg::t_in_item      i_item,
    input  wire signed [31:0]      i_range_minimum,
    input  wire [30:0]             i_bin_span,
    input  wire [8:0]              i_bins_in_use,
    output bhc_pkg::t_out_item     o_item
);
    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int SW = (AW + 1 > 9) ? AW + 1 : 9;   // size compare width
    localparam logic [SW-1:0] NB = SW'(NUM_BINS);
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // item capture
    logic [1:0]         r_action;
    logic signed [31:0] r_select;
    // division: |diff| up to 33 bits, quotient magnitude 33 bits
    logic               r_neg;
    logic [32:0]        r_rem_num;   // shifted-out numerator bits
    logic [31:0]        r_rem;       // partial remainder
    logic [30:0]        r_den;
    logic [5:0]         r_cnt;
    logic [AW-1:0]      r_clr_addr;
    // resolve
    logic signed [32:0] r_bin;
    logic [1:0]         r_place;
    logic [AW-1:0]      r_addr;
    // counters
    logic [31:0]        r_below, r_above, r_total;

    logic [31:0]  w_rdata;
    logic         w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]  w_wdata;

    logic signed [33:0] w_diff;
    logic [33:0]        w_mag;
    logic [32:0]        w_trial;
    logic [32:0]        w_q_mag;
    logic signed [33:0] w_q;
    logic signed [32:0] w_bin;
    logic [SW-1:0]      w_size;
    logic               w_is_add;
    logic               w_in_range;
    logic [31:0]        w_inc;

    assign w_diff = 34'(i_item.sample_value) - 34'(i_range_minimum);
    assign w_mag  = w_diff[33] ? -w_diff : w_diff;

    // restoring step: bring next numerator bit into the remainder
    assign w_trial = {r_rem, r_rem_num[32]} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_item.action;
            r_select  <= i_item.bin_select;
            r_neg     <= w_diff[33];
            r_rem_num <= w_mag[32:0];
            r_rem     <= '0;
            r_den     <= (i_bin_span == '0) ? 31'd1 : i_bin_span;
            r_cnt     <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
            end else begin
                r_rem <= {r_rem[30:0], r_rem_num[32]};
            end
            r_rem_num <= {r_rem_num[31:0], ~w_trial[32]};
            r_cnt     <= r_cnt + 6'd1;
        end
    end

    assign o_sts.is_divide = (r_action == bhc_pkg::ACT_ADD_VALUE);
    assign o_sts.div_last  = (r_cnt == 6'd32);
    assign o_sts.clr_last  = (r_clr_addr == AW'(NUM_BINS - 1));

    // quotient sits in r_rem_num; floor for negatives with a remainder
    assign w_q_mag = r_rem_num;
    assign w_q = r_neg ? (-$signed({1'b0, w_q_mag}) - ((r_rem != '0) ? 34'sd1 : 34'sd0))
                       : $signed({1'b0, w_q_mag});
    assign w_bin = (r_action == bhc_pkg::ACT_ADD_VALUE) ? w_q[32:0] : 33'(r_select);

    assign w_size = (SW'(i_bins_in_use) > NB) ? NB : SW'(i_bins_in_use);
    assign w_in_range = !w_bin[32] && (w_bin[31:SW] == '0) && (w_bin[SW-1:0] < w_size);

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_bin  <= w_bin;
            r_addr <= w_bin[AW-1:0];
            if (w_in_range)      r_place <= bhc_pkg::PLACE_INSIDE;
            else if (w_bin[32])  r_place <= bhc_pkg::PLACE_BELOW;
            else                 r_place <= bhc_pkg::PLACE_ABOVE;
        end
    end

    assign w_is_add = (r_action == bhc_pkg::ACT_ADD_VALUE) ||
                      (r_action == bhc_pkg::ACT_ADD_BIN);
    assign w_inc    = (w_rdata == CNT_MAX) ? w_rdata : w_rdata + 32'd1;

    assign w_we    = i_cmd.clr_step ||
                     (i_cmd.update && w_is_add && r_place == bhc_pkg::PLACE_INSIDE);
    assign w_waddr = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign w_wdata = i_cmd.clr_step ? 32'd0 : w_inc;

    bhc_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_below    <= '0;
            r_above    <= '0;
            r_total    <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd.update && w_is_add) begin
                if (r_total != CNT_MAX) r_total <= r_total + 32'd1;
                if (r_place == bhc_pkg::PLACE_BELOW && r_below != CNT_MAX)
                    r_below <= r_below + 32'd1;
                if (r_place == bhc_pkg::PLACE_ABOVE && r_above != CNT_MAX)
                    r_above <= r_above + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_item.computed_bin <= r_bin;
            o_item.placement    <= r_place;
            o_item.bin_count    <= (r_place != bhc_pkg::PLACE_INSIDE) ? 32'd0 :
                                   (w_is_add ? w_inc : w_rdata);
            o_item.total_entries   <= (w_is_add && r_total != CNT_MAX) ? r_total + 32'd1 : r_total;
            o_item.underflow_total <= (w_is_add && r_place == bhc_pkg::PLACE_BELOW &&
                                       r_below != CNT_MAX) ? r_below + 32'd1 : r_below;
            o_item.overflow_total  <= (w_is_add && r_place == bhc_pkg::PLACE_ABOVE &&
                                       r_above != CNT_MAX) ? r_above + 32'd1 : r_above;
        end
    end
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking bench for binned_histogram_counter: drives action items, writes
// the range registers over APB and compares every result against a local model.
// Depends on bhc_pkg and the binned_histogram_counter RTL.
`timescale 1ns / 1ps
module testbench;
    localparam int NBINS = 256;
    localparam longint CYCLE_LIMIT = 1_500_000;
    // unused action code; the block handles it as a read
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    bhc_pkg::t_in_item  i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    bhc_pkg::t_out_item o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    binned_histogram_counter #(.NUM_BINS(NBINS)) u_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_item,
        .o_out_valid, .i_out_ready, .o_out_item,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Model state: mirrors the block's registers and counters.
    logic signed [31:0] m_range_min;
    logic [30:0]        m_span;
    logic [8:0]         m_bins_used;
    logic [31:0]        m_bins[NBINS];
    logic [31:0]        m_below, m_above, m_add_total;

    bhc_pkg::t_in_item  item_queue[$];     // items waiting for the driver
    bhc_pkg::t_out_item expected_q[$];     // predicted results, oldest first
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off_cycles = 0;
    int        errors = 0;
    longint    cycle_count = 0;

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    // Predict one result and advance the model state.
    function automatic bhc_pkg::t_out_item histogram_step(bhc_pkg::t_in_item it);
        bhc_pkg::t_out_item r;
        longint size, bw, num, q, bin;
        logic inside_rng;
        size = (m_bins_used > NBINS) ? NBINS : longint'(m_bins_used);
        bw   = (m_span == 0) ? 1 : longint'(m_span);
        if (it.action == bhc_pkg::ACT_ADD_VALUE) begin
            num = longint'(it.sample_value) - longint'(m_range_min);
            q = num / bw;
            if ((num % bw) != 0 && num < 0) q = q - 1;
            bin = q;
        end else begin
            bin = longint'(it.bin_select);
        end
        inside_rng = (bin >= 0) && (bin < size);
        r.placement = inside_rng ? bhc_pkg::PLACE_INSIDE
                                 : (bin < 0 ? bhc_pkg::PLACE_BELOW : bhc_pkg::PLACE_ABOVE);
        if (it.action == bhc_pkg::ACT_ADD_VALUE || it.action == bhc_pkg::ACT_ADD_BIN) begin
            if (inside_rng) m_bins[bin] = sat_inc(m_bins[bin]);
            else if (bin < 0) m_below = sat_inc(m_below);
            else m_above = sat_inc(m_above);
            m_add_total = sat_inc(m_add_total);
        end
        r.computed_bin    = bin[32:0];
        r.bin_count       = inside_rng ? m_bins[bin] : 32'd0;
        r.total_entries   = m_add_total;
        r.underflow_total = m_below;
        r.overflow_total  = m_above;
        return r;
    endfunction

    // Driver: present the head of the queue, hold it until accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_q.push_back(histogram_step(i_in_item));
                void'(item_queue.pop_front());
            end
            if ((!i_in_valid || o_in_ready) && item_queue.size() > 0 &&
                !(i_in_valid && o_in_ready && item_queue.size() == 0)) begin
                if ($urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= item_queue[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (i_in_valid && o_in_ready) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check every taken result against the oldest prediction.
    always @(posedge i_clk) begin
        bhc_pkg::t_out_item exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no prediction pending");
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (o_out_item.computed_bin !== exp_r.computed_bin) begin
                        $error("computed_bin exp %0d got %0d", exp_r.computed_bin,
                               o_out_item.computed_bin);
                        errors++;
                    end
                    if (o_out_item.placement !== exp_r.placement) begin
                        $error("placement exp %0d got %0d", exp_r.placement,
                               o_out_item.placement);
                        errors++;
                    end
                    if (o_out_item.bin_count !== exp_r.bin_count) begin
                        $error("bin_count exp %0d got %0d", exp_r.bin_count,
                               o_out_item.bin_count);
                        errors++;
                    end
                    if (o_out_item.total_entries !== exp_r.total_entries) begin
                        $error("total_entries exp %0d got %0d", exp_r.total_entries,
                               o_out_item.total_entries);
                        errors++;
                    end
                    if (o_out_item.underflow_total !== exp_r.underflow_total) begin
                        $error("underflow_total exp %0d got %0d", exp_r.underflow_total,
                               o_out_item.underflow_total);
                        errors++;
                    end
                    if (o_out_item.overflow_total !== exp_r.overflow_total) begin
                        $error("overflow_total exp %0d got %0d", exp_r.overflow_total,
                               o_out_item.overflow_total);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver: a long hold-off has priority over random stalls.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Two-phase APB write; the register updates on the access edge.
    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (reg_idx)
            bhc_pkg::REG_RANGE_MIN: m_range_min = value;
            bhc_pkg::REG_BIN_WIDTH: m_span = value[30:0];
            bhc_pkg::REG_BINS_USED: m_bins_used = value[8:0];
            default: ;
        endcase
    endtask

    task automatic push_item(logic [1:0] act, logic [31:0] sv, logic [31:0] bs);
        bhc_pkg::t_in_item it;
        it.action = act; it.sample_value = sv; it.bin_select = bs;
        item_queue.push_back(it);
    endtask

    // Wait until every item is taken and every result checked, then let the
    // block settle for longer than its longest latency.
    task automatic drain();
        while (item_queue.size() > 0 || i_in_valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Random items: values mostly near the configured range so every bin,
    // underflow and overflow are hit; a slice of fully random noise.
    task automatic random_items(int n);
        longint span;
        logic [31:0] v;
        span = longint'(m_span) * (m_bins_used + 2);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 7)
                v = 32'(longint'(m_range_min) - longint'(m_span) +
                        longint'($urandom_range(32'(span > 32'hFFFF_FFFF ?
                                                    32'hFFFF_FFFF : span))));
            else
                v = $urandom;
            case ($urandom_range(3))
                0, 1: push_item(bhc_pkg::ACT_ADD_VALUE, v, $urandom);
                2:    push_item(bhc_pkg::ACT_ADD_BIN, $urandom,
                                ($urandom_range(3) == 0) ? $urandom
                                    : 32'($urandom_range(300)) - 32'd20);
                default: push_item($urandom_range(1) ? bhc_pkg::ACT_READ_BIN : ACT_SPARE,
                                   $urandom,
                                   ($urandom_range(3) == 0) ? $urandom
                                       : 32'($urandom_range(300)) - 32'd20);
            endcase
        end
    endtask

    initial begin
        m_range_min = 0; m_span = 1; m_bins_used = 256;
        for (int k = 0; k < NBINS; k++) m_bins[k] = '0;
        m_below = 0; m_above = 0; m_add_total = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset config, field extremes, every action and the spare code.
        push_item(bhc_pkg::ACT_ADD_VALUE, 32'sd0, 32'sd0);
        push_item(bhc_pkg::ACT_ADD_VALUE, 32'sd255, 32'sd0);
        push_item(bhc_pkg::ACT_ADD_VALUE, 32'sd256, 32'sd0);
        push_item(bhc_pkg::ACT_ADD_VALUE, -32'sd1, 32'sd0);
        push_item(bhc_pkg::ACT_ADD_VALUE, 32'h8000_0000, 32'hFFFF_FFFF);
        push_item(bhc_pkg::ACT_ADD_VALUE, 32'h7FFF_FFFF, 32'h8000_0000);
        push_item(bhc_pkg::ACT_ADD_BIN, 32'hFFFF_FFFF, 32'sd0);
        push_item(bhc_pkg::ACT_ADD_BIN, 32'sd0, 32'h8000_0000);
        push_item(bhc_pkg::ACT_ADD_BIN, 32'sd0, 32'h7FFF_FFFF);
        push_item(bhc_pkg::ACT_ADD_BIN, 32'sd0, 32'sd255);
        push_item(bhc_pkg::ACT_READ_BIN, 32'sd0, 32'sd0);
        push_item(bhc_pkg::ACT_READ_BIN, 32'sd0, -32'sd1);
        push_item(bhc_pkg::ACT_READ_BIN, 32'sd0, 32'sd256);
        push_item(ACT_SPARE, 32'sd0, 32'sd255);
        drain();

        // Negative minimum, wide bins: floor of values just below minimum.
        apb_write(bhc_pkg::REG_RANGE_MIN, -32'sd100);
        apb_write(bhc_pkg::REG_BIN_WIDTH, 32'd7);
        apb_write(bhc_pkg::REG_BINS_USED, 32'd10);
        push_item(bhc_pkg::ACT_ADD_VALUE, -32'sd101, 0);
        push_item(bhc_pkg::ACT_ADD_VALUE, -32'sd100, 0);
        push_item(bhc_pkg::ACT_ADD_VALUE, -32'sd31, 0);
        push_item(bhc_pkg::ACT_ADD_VALUE, -32'sd30, 0);
        drain();

        // Zero width, zero bins, oversized bin count.
        apb_write(bhc_pkg::REG_BIN_WIDTH, 32'd0);
        apb_write(bhc_pkg::REG_BINS_USED, 32'd0);
        push_item(bhc_pkg::ACT_ADD_VALUE, -32'sd100, 0);
        push_item(bhc_pkg::ACT_ADD_VALUE, -32'sd101, 0);
        push_item(bhc_pkg::ACT_ADD_BIN, 0, 32'sd0);
        drain();
        apb_write(bhc_pkg::REG_BINS_USED, 32'h1FF);
        apb_write(bhc_pkg::REG_BIN_WIDTH, 32'h7FFF_FFFF);
        apb_write(bhc_pkg::REG_RANGE_MIN, 32'h8000_0000);
        push_item(bhc_pkg::ACT_ADD_VALUE, 32'h7FFF_FFFF, 0);
        push_item(bhc_pkg::ACT_ADD_VALUE, 32'h8000_0000, 0);
        push_item(bhc_pkg::ACT_READ_BIN, 0, 32'sd1);
        drain();

        // Random phases across several settings and idling mixes.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin apb_write(bhc_pkg::REG_RANGE_MIN, 32'd0);
                         apb_write(bhc_pkg::REG_BIN_WIDTH, 32'd1);
                         apb_write(bhc_pkg::REG_BINS_USED, 32'd256); end
                1: begin apb_write(bhc_pkg::REG_RANGE_MIN, -32'sd5000);
                         apb_write(bhc_pkg::REG_BIN_WIDTH, 32'd37);
                         apb_write(bhc_pkg::REG_BINS_USED, 32'd200); end
                2: begin apb_write(bhc_pkg::REG_RANGE_MIN, 32'h7FFF_0000);
                         apb_write(bhc_pkg::REG_BIN_WIDTH, 32'd3);
                         apb_write(bhc_pkg::REG_BINS_USED, 32'd1); end
                3: begin apb_write(bhc_pkg::REG_RANGE_MIN, $urandom);
                         apb_write(bhc_pkg::REG_BIN_WIDTH, $urandom_range(1, 1000));
                         apb_write(bhc_pkg::REG_BINS_USED, $urandom_range(1, 256)); end
                default: begin apb_write(bhc_pkg::REG_RANGE_MIN, -32'sd1);
                         apb_write(bhc_pkg::REG_BIN_WIDTH, 32'd16);
                         apb_write(bhc_pkg::REG_BINS_USED, 32'd64); end
            endcase
            send_idle_pct  = (ph == 1 || ph == 3) ? 86 : 0;
            recv_stall_pct = (ph == 2) ? 86 : (ph == 3) ? 23 : 0;
            if (ph == 3) send_idle_pct = 23;
            // Long receiver hold-off while items keep coming.
            if (ph == 4) hold_off_cycles = 400;
            random_items(90);
            drain();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
